// File: sv/sqmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square matrix multiply package
// Shared widths, defaults and the cell-to-cell link type.
// ----------------------------------------------------------------------------
package sqmm_pkg;

	localparam int DEF_MAX_DIM = 8;
	localparam int SIZE_W      = 4;
	localparam int SIZE_RST    = 8;
	localparam int ELEM_W      = 16;
	localparam int PROD_W      = 32;
	localparam int ACC_W       = 48;
	localparam int IDX_OUT_W   = 3;

	typedef struct packed {
		logic                     valid;
		logic                     first;
		logic signed [ELEM_W-1:0] a;
	} link_t;

endpackage
`default_nettype wire

// File: sv/sqmm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square matrix multiply cell
// Holds one column of B and the accumulator for one result column. Left
// elements arrive from the previous cell and are passed on in the next cycle.
// ----------------------------------------------------------------------------
module sqmm_cell import sqmm_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire   link_t                      link_in,
	output link_t                             link_out,
	input  wire                               b_we,
	input  wire  [$clog2(MAX_DIM)-1:0]        b_row,
	input  wire  signed [ELEM_W-1:0]          b_data,
	input  wire                               shift_en,
	input  wire  signed [ACC_W-1:0]           acc_in,
	output logic signed [ACC_W-1:0]           acc_out
);

	localparam int IW = $clog2(MAX_DIM);

	logic signed [ELEM_W-1:0] b_col_q [MAX_DIM];
	link_t                    lnk_s1;
	logic [IW-1:0]            k_q;
	logic [IW-1:0]            k_rd;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic                     first_s2;
	logic signed [ACC_W-1:0]  acc_q;

	assign k_rd = lnk_s1.first ? '0 : k_q;

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_col_q[b_row] <= b_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lnk_s1   <= '0;
			vld_s2   <= 1'b0;
			first_s2 <= 1'b0;
			k_q      <= '0;
		end else begin
			lnk_s1   <= link_in;
			vld_s2   <= lnk_s1.valid;
			first_s2 <= lnk_s1.first;
			if (lnk_s1.valid) begin
				k_q <= k_rd + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'($signed(lnk_s1.a)) * PROD_W'($signed(b_col_q[k_rd]));
		if (vld_s2) begin
			if (first_s2) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end else if (shift_en) begin
			acc_q <= acc_in;
		end
	end

	assign link_out = lnk_s1;
	assign acc_out  = acc_q;

endmodule
`default_nettype wire

// File: sv/sqmm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square matrix multiply controller
// Loads the operand pairs, feeds rows of A into the cell chain and sequences
// the readout of each result row.
// ----------------------------------------------------------------------------
module sqmm_ctrl import sqmm_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [SIZE_W-1:0]            cfg_wdata,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  signed [ELEM_W-1:0]     a_element,
	input  wire  signed [ELEM_W-1:0]     b_element,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [IDX_OUT_W-1:0]         row_index,
	output logic [IDX_OUT_W-1:0]         col_index,
	output logic                         last_result,
	output link_t                        link_out,
	output logic                         b_we,
	output logic [$clog2(MAX_DIM)-1:0]   b_row,
	output logic [$clog2(MAX_DIM)-1:0]   b_col,
	output logic signed [ELEM_W-1:0]     b_data,
	output logic                         shift_en
);

	localparam int IW      = $clog2(MAX_DIM);
	localparam int DW      = $clog2(MAX_DIM + 1);
	localparam int AW      = $clog2(MAX_DIM * MAX_DIM);
	localparam int DRW     = $clog2(MAX_DIM + 4);
	localparam int RST_DIM = (SIZE_RST > MAX_DIM) ? MAX_DIM : SIZE_RST;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [DW-1:0]            dim_q;
	logic [DW-1:0]            dim_new;
	logic [IW-1:0]            dim_m1;
	logic [IW-1:0]            r_q;
	logic [IW-1:0]            c_q;
	logic [IW-1:0]            i_q;
	logic [IW-1:0]            k_q;
	logic [IW-1:0]            j_q;
	logic [DRW-1:0]           drain_q;
	logic [DRW-1:0]           drain_end;
	logic [AW-1:0]            a_wa;
	logic [AW-1:0]            a_ra;
	logic                     a_we;
	logic signed [ELEM_W-1:0] amem [MAX_DIM*MAX_DIM];
	logic signed [ELEM_W-1:0] a_rd_s1;
	logic                     rd_vld_s1;
	logic                     rd_first_s1;

	always_comb begin
		if (cfg_wdata == '0) begin
			dim_new = DW'(1);
		end else if (32'(cfg_wdata) > MAX_DIM) begin
			dim_new = DW'(MAX_DIM);
		end else begin
			dim_new = DW'(cfg_wdata);
		end
	end

	assign dim_m1    = IW'(dim_q - DW'(1));
	assign drain_end = DRW'(dim_q) + DRW'(3);
	assign a_we      = (state_q == ST_LOAD) && in_valid;
	assign a_wa      = AW'(32'(r_q) * MAX_DIM + 32'(c_q));
	assign a_ra      = AW'(32'(i_q) * MAX_DIM + 32'(k_q));

	always_ff @(posedge clk) begin
		if (a_we) begin
			amem[a_wa] <= a_element;
		end
		if (state_q == ST_ISSUE) begin
			a_rd_s1 <= amem[a_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			dim_q       <= DW'(RST_DIM);
			r_q         <= '0;
			c_q         <= '0;
			i_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			drain_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
		end else begin
			rd_vld_s1   <= (state_q == ST_ISSUE);
			rd_first_s1 <= (k_q == '0);
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (c_q == dim_m1) begin
							c_q <= '0;
							if (r_q == dim_m1) begin
								r_q     <= '0;
								i_q     <= '0;
								k_q     <= '0;
								state_q <= ST_ISSUE;
							end else begin
								r_q <= r_q + IW'(1);
							end
						end else begin
							c_q <= c_q + IW'(1);
						end
					end
				end
				ST_ISSUE: begin
					if (k_q == dim_m1) begin
						k_q     <= '0;
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					if (drain_q == drain_end) begin
						j_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						drain_q <= drain_q + DRW'(1);
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						if (j_q == dim_m1) begin
							j_q <= '0;
							if (i_q == dim_m1) begin
								i_q     <= '0;
								state_q <= ST_LOAD;
							end else begin
								i_q     <= i_q + IW'(1);
								k_q     <= '0;
								state_q <= ST_ISSUE;
							end
						end else begin
							j_q <= j_q + IW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
			// A size write discards any partly loaded matrices.
			if (cfg_we) begin
				dim_q <= dim_new;
				r_q   <= '0;
				c_q   <= '0;
			end
		end
	end

	assign in_ready       = (state_q == ST_LOAD);
	assign out_valid      = (state_q == ST_EMIT);
	assign row_index      = IDX_OUT_W'(i_q);
	assign col_index      = IDX_OUT_W'(j_q);
	assign last_result    = out_valid && (i_q == dim_m1) && (j_q == dim_m1);
	assign link_out.valid = rd_vld_s1;
	assign link_out.first = rd_first_s1;
	assign link_out.a     = a_rd_s1;
	assign b_we           = a_we;
	assign b_row          = r_q;
	assign b_col          = c_q;
	assign b_data         = b_element;
	assign shift_en       = out_valid && out_ready;

endmodule
`default_nettype wire

// File: sv/square_matrix_multiply.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square matrix multiply
// Computes C = A*B for n-by-n signed Q8.8 matrices with exact Q32.16 results.
// ----------------------------------------------------------------------------
// Pairs of A and B elements are taken in row-major order at one item per
// cycle, n*n of them. The block then works through C one row at a time: a row
// of A is streamed into a chain of MAX_DIM cells, each of which owns one
// column of B and one accumulator, and the chain is flushed, after which the n
// results of the row shift out of the first cell at one item per cycle while
// out_ready is high. The row of A is issued through the single read port of
// the A store. No input is taken while results are computed or delivered.
// ----------------------------------------------------------------------------
module square_matrix_multiply import sqmm_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire  [SIZE_W-1:0]         cfg_wdata,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire  signed [ELEM_W-1:0]  a_element,
	input  wire  signed [ELEM_W-1:0]  b_element,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [IDX_OUT_W-1:0]      row_index,
	output logic [IDX_OUT_W-1:0]      col_index,
	output logic signed [ACC_W-1:0]   product_element,
	output logic                      last_result
);

	localparam int IW = $clog2(MAX_DIM);

	link_t                    link [MAX_DIM+1];
	logic signed [ACC_W-1:0]  acc  [MAX_DIM+1];
	logic                     b_we;
	logic [IW-1:0]            b_row;
	logic [IW-1:0]            b_col;
	logic signed [ELEM_W-1:0] b_data;
	logic                     shift_en;

	sqmm_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.a_element   (a_element),
		.b_element   (b_element),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.row_index   (row_index),
		.col_index   (col_index),
		.last_result (last_result),
		.link_out    (link[0]),
		.b_we        (b_we),
		.b_row       (b_row),
		.b_col       (b_col),
		.b_data      (b_data),
		.shift_en    (shift_en)
	);

	assign acc[MAX_DIM] = '0;

	for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
		sqmm_cell #(
			.MAX_DIM (MAX_DIM)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.link_in  (link[g]),
			.link_out (link[g+1]),
			.b_we     (b_we && (32'(b_col) == g)),
			.b_row    (b_row),
			.b_data   (b_data),
			.shift_en (shift_en),
			.acc_in   (acc[g+1]),
			.acc_out  (acc[g])
		);
	end

	assign product_element = acc[0];

endmodule
`default_nettype wire

// File: sv/sqmm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square matrix multiply checker
// Port-level properties of the multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module sqmm_checker import sqmm_pkg::*; (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      in_valid,
	input wire                      in_ready,
	input wire                      out_valid,
	input wire                      out_ready,
	input wire [IDX_OUT_W-1:0]      row_index,
	input wire [IDX_OUT_W-1:0]      col_index,
	input wire signed [ACC_W-1:0]   product_element,
	input wire                      last_result
);

	// Loading and delivery never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while results are pending");

	// The final result sits on the diagonal corner.
	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_result) |-> (row_index == col_index))
		else $error("last result off the diagonal");

	// After the final item is taken the block returns to loading.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_result) |=> (!out_valid && in_ready))
		else $error("results continue after the last item");

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(product_element)
			&& $stable(row_index) && $stable(col_index)))
		else $error("stalled result changed");

endmodule

bind square_matrix_multiply sqmm_checker u_sqmm_checker (.*);
`default_nettype wire

// File: tb/tb_square_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix multiply testbench
// Streams pairs of A and B elements into the block under a range of matrix
// sizes. It predicts every element of C = A*B and checks the results in order.
// ----------------------------------------------------------------------------
// A directed opening covers full-scale positive and negative elements, sizes
// one and zero, and a size change that drops a partly loaded matrix. Random
// phases follow, each with its own size (saturating codes among them), random
// content, partial loads and random idling on both handshakes. The end of the
// run has no idling.
// ----------------------------------------------------------------------------
module tb_square_matrix_multiply;
	import sqmm_pkg::*;

	localparam int CELL_COUNT = DEF_MAX_DIM * DEF_MAX_DIM;
	localparam int ITEM_TARGET = 310;
	localparam int CALM_FROM = 260;

	typedef struct {
		logic [IDX_OUT_W-1:0]    row;
		logic [IDX_OUT_W-1:0]    col;
		logic signed [ACC_W-1:0] value;
		logic                    last;
	} cell_t;

	class product_scoreboard;
		logic [SIZE_W-1:0]        size_code;
		logic signed [ELEM_W-1:0] left_m [CELL_COUNT];
		logic signed [ELEM_W-1:0] right_m [CELL_COUNT];
		int unsigned              loaded;
		cell_t                    expected_cells [$];
		int                       errors;

		function new();
			size_code = SIZE_RST;
			loaded = 0;
			errors = 0;
		endfunction

		function int unsigned active_dim();
			int unsigned n;
			n = size_code;
			if (n == 0) begin
				n = 1;
			end
			if (n > DEF_MAX_DIM) begin
				n = DEF_MAX_DIM;
			end
			return n;
		endfunction

		function int outstanding();
			return expected_cells.size();
		endfunction

		function void set_size(logic [SIZE_W-1:0] code);
			size_code = code;
			loaded = 0;
		endfunction

		function void note_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b);
			int unsigned              n;
			int unsigned              total;
			logic signed [ACC_W-1:0]  sum;
			logic signed [PROD_W-1:0] term;
			cell_t                    c;
			n = active_dim();
			total = n * n;
			if (loaded >= total) begin
				loaded = 0;
			end
			left_m[loaded] = a;
			right_m[loaded] = b;
			loaded++;
			if (loaded < total) begin
				return;
			end
			loaded = 0;
			for (int i = 0; i < n; i++) begin
				for (int j = 0; j < n; j++) begin
					sum = '0;
					for (int k = 0; k < n; k++) begin
						term = left_m[i * n + k] * right_m[k * n + j];
						sum = sum + term;
					end
					c.row = IDX_OUT_W'(i);
					c.col = IDX_OUT_W'(j);
					c.value = sum;
					c.last = (i == n - 1) && (j == n - 1);
					expected_cells.push_back(c);
				end
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) begin
				$display("MISMATCH at %0t: %s", $time, msg);
			end
		endtask

		task check_cell(logic [IDX_OUT_W-1:0] row, logic [IDX_OUT_W-1:0] col,
				logic signed [ACC_W-1:0] value, logic last);
			cell_t e;
			if (expected_cells.size() == 0) begin
				report($sformatf("unexpected result row %0d col %0d value %0d",
					row, col, value));
				return;
			end
			e = expected_cells.pop_front();
			if (row !== e.row) begin
				report($sformatf("row_index %0d, expected %0d", row, e.row));
			end
			if (col !== e.col) begin
				report($sformatf("col_index %0d, expected %0d", col, e.col));
			end
			if (value !== e.value) begin
				report($sformatf("product_element %0d, expected %0d at row %0d col %0d",
					value, e.value, e.row, e.col));
			end
			if (last !== e.last) begin
				report($sformatf("last_result %0b, expected %0b at row %0d col %0d",
					last, e.last, e.row, e.col));
			end
		endtask
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [SIZE_W-1:0]          cfg_wdata;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [ELEM_W-1:0]   a_element;
	logic signed [ELEM_W-1:0]   b_element;
	logic                       out_valid;
	logic                       out_ready;
	logic [IDX_OUT_W-1:0]       row_index;
	logic [IDX_OUT_W-1:0]       col_index;
	logic signed [ACC_W-1:0]    product_element;
	logic                       last_result;

	product_scoreboard sb = new();
	int unsigned       sent = 0;
	int unsigned       gap_pct = 20;
	int unsigned       stall_pct = 20;
	bit                calm = 1'b0;

	square_matrix_multiply uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.a_element      (a_element),
		.b_element      (b_element),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.row_index      (row_index),
		.col_index      (col_index),
		.product_element(product_element),
		.last_result    (last_result)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready === 1'b1) begin
				sb.note_pair(a_element, b_element);
			end
			if (out_valid === 1'b1 && out_ready) begin
				sb.check_cell(row_index, col_index, product_element, last_result);
			end
		end
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	function automatic logic signed [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3: return ELEM_W'($urandom_range(0, 15) - 8);
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			return SIZE_W'($urandom_range(1, 3));
		end
		if (r < 55) begin
			return SIZE_W'($urandom_range(4, 5));
		end
		if (r < 65) begin
			return SIZE_W'($urandom_range(6, 7));
		end
		if (r < 75) begin
			return SIZE_W'(DEF_MAX_DIM);
		end
		if (r < 87) begin
			return SIZE_W'($urandom_range(DEF_MAX_DIM + 1, 15));
		end
		return '0;
	endfunction

	task automatic send_pair(input logic signed [ELEM_W-1:0] a,
			input logic signed [ELEM_W-1:0] b);
		calm = (sent >= CALM_FROM);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		a_element <= a;
		b_element <= b;
		do begin
			@(posedge clk);
		end while (in_ready !== 1'b1);
		sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.outstanding() != 0);
	endtask

	task automatic set_size(input logic [SIZE_W-1:0] code);
		wait_drained();
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		sb.set_size(code);
		cfg_we <= 1'b0;
	endtask

	initial begin
		bit          first_phase;
		int unsigned total;
		int unsigned mats;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		a_element <= '0;
		b_element <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 30;
		stall_pct = 30;
		repeat (3) send_pair(rand_elem(), rand_elem());
		set_size(SIZE_W'(2));
		repeat (4) send_pair(16'sh7FFF, 16'sh7FFF);
		repeat (4) send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7FFF, 16'sh8000);
		send_pair(16'sh8000, 16'sh7FFF);
		send_pair(16'sh8000, 16'sh7FFF);
		send_pair(16'sh7FFF, 16'sh8000);
		set_size(SIZE_W'(1));
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7FFF, 16'sh8000);
		send_pair(16'sh0000, 16'sh1234);
		set_size('0);
		send_pair(16'sh8000, 16'sh7FFF);
		send_pair(16'sh0001, 16'shFFFF);

		first_phase = 1'b1;
		while (sent < ITEM_TARGET) begin
			set_size(first_phase ? 4'hF : pick_size());
			first_phase = 1'b0;
			gap_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
			stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
			total = sb.active_dim() * sb.active_dim();
			mats = (total > 25) ? 1 : $urandom_range(1, 3);
			repeat (mats) begin
				if ($urandom_range(0, 3) == 0) begin
					wait_drained();
				end
				repeat (total) send_pair(rand_elem(), rand_elem());
			end
			if (total > 1 && sent < CALM_FROM && $urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, total - 1)) send_pair(rand_elem(), rand_elem());
			end
		end

		wait_drained();
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("tb_square_matrix_multiply: done, clean");
		end else begin
			$display("tb_square_matrix_multiply: done, errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_square_matrix_multiply: done, errors");
		$finish;
	end

endmodule

// File: sim.f
sv/sqmm_pkg.sv
sv/sqmm_cell.sv
sv/sqmm_ctrl.sv
sv/square_matrix_multiply.sv
sv/sqmm_checker.sv
tb/tb_square_matrix_multiply.sv
